// ----- sv/call_stack_exclusive_time_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the call stack exclusive time block
// Shared property forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CALL_STACK_EXCLUSIVE_TIME_TOP_MACROS_SVH
`define CALL_STACK_EXCLUSIVE_TIME_TOP_MACROS_SVH

// cond holds at every edge out of reset
`define CSX_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// ante implies cons in the same cycle
`define CSX_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- sv/csx_pkg.sv -----
// ----------------------------------------------------------------------------
// csx_pkg
// Shared constants, codes and types of the call stack exclusive time block.
// ----------------------------------------------------------------------------
package csx_pkg;

	localparam int NUM_FUNCS   = 128;
	localparam int STACK_DEPTH = 64;

	localparam int REQ_W = 2;
	localparam int ID_W  = 7;
	localparam int TS_W  = 32;
	localparam int TOT_W = 40;
	localparam int ST_W  = 2;
	localparam int DUR_W = TS_W + 2;

	localparam int SCNT_W    = $clog2(STACK_DEPTH + 1);
	localparam int SADDR_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int TOT_DEPTH = (NUM_FUNCS < (2 ** ID_W)) ? NUM_FUNCS : (2 ** ID_W);
	localparam int TADDR_W   = (TOT_DEPTH > 1) ? $clog2(TOT_DEPTH) : 1;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [REQ_W-1:0] REQ_START = 2'd0;
	localparam logic [REQ_W-1:0] REQ_END   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		OP_START,
		OP_END,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [ID_W-1:0] id;
		logic            id_ok;
		logic [TS_W-1:0] ts;
	} q_item_t;

	typedef struct packed {
		logic [ID_W-1:0]         id;
		logic signed [TOT_W-1:0] total;
		logic [ST_W-1:0]         status;
	} result_t;

	typedef struct packed {
		logic [QCNT_W-1:0] level;
	} front_stat_t;

	typedef struct packed {
		logic              busy;
		logic [SCNT_W-1:0] stack_cnt;
	} back_stat_t;

endpackage

// ----- sv/call_stack_exclusive_time_top.sv -----
// ----------------------------------------------------------------------------
// call_stack_exclusive_time_top
// Exclusive time profiler: call stack of start events, per-function totals
// updated on end events, totals returned on every event.
//
//   channel   handshake          payload
//   events    push / full        req_type, func_id, timestamp
//   results   pop / empty        result_id, exclusive_total, status
//
// Start, read and an end with no caller frame finish in S_LOOK; an end that
// leaves a caller frame runs S_PAR and S_SUB, a read-modify-write of two
// entries in the single-port totals memory. Totals read as zero after reset
// through per-entry valid flags, so there is no clearing pass. A four-beat
// queue holds events while the back end or the result register is stalled.
// ----------------------------------------------------------------------------
`include "call_stack_exclusive_time_top_macros.svh"

module call_stack_exclusive_time_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [csx_pkg::REQ_W-1:0]          req_type,
	input  logic [csx_pkg::ID_W-1:0]           func_id,
	input  logic [csx_pkg::TS_W-1:0]           timestamp,
	output logic                               empty,
	input  logic                               pop,
	output logic [csx_pkg::ID_W-1:0]           result_id,
	output logic signed [csx_pkg::TOT_W-1:0]   exclusive_total,
	output logic [csx_pkg::ST_W-1:0]           status
);

	logic                   q_pop;
	logic                   q_empty;
	csx_pkg::q_item_t       q_head;
	csx_pkg::front_stat_t   front_stat;
	csx_pkg::back_stat_t    back_stat;
	logic                   res_valid;
	csx_pkg::result_t       res;
	csx_pkg::result_t       out_q;
	logic                   out_valid_q;
	logic                   out_free;

	csx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req_type  (req_type),
		.func_id   (func_id),
		.timestamp (timestamp),
		.q_pop     (q_pop),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.stat      (front_stat)
	);

	csx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res),
		.stat      (back_stat)
	);

	assign out_free        = !out_valid_q || pop;
	assign empty           = !out_valid_q;
	assign result_id       = out_q.id;
	assign exclusive_total = out_q.total;
	assign status          = out_q.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (res_valid) begin
				out_valid_q <= 1'b1;
				out_q       <= res;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`CSX_ASSERT_IMP(a_busy_out_empty, back_stat.busy, !out_valid_q, "result register held during event")
	`CSX_ASSERT_ALWAYS(a_stack_bound, back_stat.stack_cnt <= csx_pkg::SCNT_W'(csx_pkg::STACK_DEPTH), "stack count overrun")
	`CSX_ASSERT_ALWAYS(a_queue_bound, front_stat.level <= csx_pkg::QCNT_W'(csx_pkg::QDEPTH), "queue level overrun")
	`CSX_ASSERT_IMP(a_full_status, res_valid && res.status == csx_pkg::ST_FULL, back_stat.stack_cnt == csx_pkg::SCNT_W'(csx_pkg::STACK_DEPTH), "stack full flagged below depth")

endmodule

// ----- sv/csx_front.sv -----
// ----------------------------------------------------------------------------
// csx_front
// Accepts event beats, decodes the request and queues them for the back end.
// ----------------------------------------------------------------------------
module csx_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [csx_pkg::REQ_W-1:0]          req_type,
	input  logic [csx_pkg::ID_W-1:0]           func_id,
	input  logic [csx_pkg::TS_W-1:0]           timestamp,
	input  logic                               q_pop,
	output logic                               q_empty,
	output csx_pkg::q_item_t                   q_head,
	output csx_pkg::front_stat_t               stat
);

	csx_pkg::q_item_t            q_mem_q [csx_pkg::QDEPTH];
	logic [csx_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [csx_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [csx_pkg::QCNT_W-1:0]  level_q;
	csx_pkg::q_item_t            in_item;
	logic                        wr_en;
	logic                        rd_en;

	always_comb begin
		unique case (req_type)
			csx_pkg::REQ_START: in_item.op = csx_pkg::OP_START;
			csx_pkg::REQ_END:   in_item.op = csx_pkg::OP_END;
			default:            in_item.op = csx_pkg::OP_READ;
		endcase
		in_item.id    = func_id;
		in_item.id_ok = (int'(func_id) < csx_pkg::NUM_FUNCS);
		in_item.ts    = timestamp;
	end

	assign full    = (level_q == csx_pkg::QCNT_W'(csx_pkg::QDEPTH));
	assign q_empty = (level_q == '0);
	assign wr_en   = push && !full;
	assign rd_en   = q_pop && !q_empty;
	assign q_head  = q_mem_q[rd_ptr_q];
	assign stat.level = level_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			q_mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				level_q <= level_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/csx_back.sv -----
// ----------------------------------------------------------------------------
// csx_back
// Call stack and exclusive time totals; sequences each event through the
// frame memory and the totals memory and hands one result out per event.
// ----------------------------------------------------------------------------
module csx_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  csx_pkg::q_item_t      q_head,
	output logic                  q_pop,
	input  logic                  out_free,
	output logic                  res_valid,
	output csx_pkg::result_t      res,
	output csx_pkg::back_stat_t   stat
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_PAR,
		S_SUB
	} state_t;

	localparam int FRM_W = csx_pkg::ID_W + csx_pkg::TS_W;

	function automatic logic signed [csx_pkg::TOT_W-1:0] sat_add(
		input logic signed [csx_pkg::TOT_W-1:0] a,
		input logic [csx_pkg::DUR_W-1:0]        d
	);
		logic [csx_pkg::TOT_W:0] s;
		s = {a[csx_pkg::TOT_W-1], a}
			+ {{(csx_pkg::TOT_W + 1 - csx_pkg::DUR_W){d[csx_pkg::DUR_W-1]}}, d};
		if (s[csx_pkg::TOT_W] != s[csx_pkg::TOT_W-1]) begin
			return s[csx_pkg::TOT_W] ? {1'b1, {(csx_pkg::TOT_W-1){1'b0}}}
				: {1'b0, {(csx_pkg::TOT_W-1){1'b1}}};
		end
		return s[csx_pkg::TOT_W-1:0];
	endfunction

	state_t                              state_q, state_d;
	csx_pkg::q_item_t                    item_q, item_d;
	logic [csx_pkg::SCNT_W-1:0]          scnt_q, scnt_d;
	logic [csx_pkg::ST_W-1:0]            status_q, status_d;
	logic [csx_pkg::DUR_W-1:0]           dur_q, dur_d;
	logic signed [csx_pkg::TOT_W-1:0]    res_tot_q, res_tot_d;

	logic [FRM_W-1:0]                    stk_mem [csx_pkg::STACK_DEPTH];
	logic [FRM_W-1:0]                    stk_rdata_q;
	logic                                stk_we, stk_re;
	logic [csx_pkg::SADDR_W-1:0]         stk_waddr, stk_raddr;

	logic signed [csx_pkg::TOT_W-1:0]    tot_mem [csx_pkg::TOT_DEPTH];
	logic [csx_pkg::TOT_DEPTH-1:0]       tot_vld_q;
	logic signed [csx_pkg::TOT_W-1:0]    tot_rdata_q;
	logic                                tot_rvld_q;
	logic                                tot_we, tot_re;
	logic [csx_pkg::TADDR_W-1:0]         tot_waddr, tot_raddr;
	logic signed [csx_pkg::TOT_W-1:0]    tot_wdata;
	logic signed [csx_pkg::TOT_W-1:0]    tot_rd_val;

	logic [csx_pkg::ID_W-1:0]            par_id;
	logic                                par_ok;
	logic [csx_pkg::TS_W-1:0]            top_t0;
	logic signed [csx_pkg::TOT_W-1:0]    new_tot, sub_tot;
	logic [csx_pkg::DUR_W-1:0]           cur_dur;

	assign tot_rd_val = tot_rvld_q ? tot_rdata_q : '0;
	assign par_id     = stk_rdata_q[FRM_W-1:csx_pkg::TS_W];
	assign top_t0     = stk_rdata_q[csx_pkg::TS_W-1:0];
	assign par_ok     = (int'(par_id) < csx_pkg::NUM_FUNCS);
	assign cur_dur    = {2'b00, item_q.ts} - {2'b00, top_t0} + csx_pkg::DUR_W'(1);
	assign new_tot    = sat_add(tot_rd_val, cur_dur);
	assign sub_tot    = sat_add(tot_rd_val, csx_pkg::DUR_W'(0) - dur_q);

	assign stat.busy      = (state_q != S_IDLE);
	assign stat.stack_cnt = scnt_q;

	always_comb begin
		state_d   = state_q;
		item_d    = item_q;
		scnt_d    = scnt_q;
		status_d  = status_q;
		dur_d     = dur_q;
		res_tot_d = res_tot_q;
		q_pop     = 1'b0;
		stk_we    = 1'b0;
		stk_re    = 1'b0;
		stk_waddr = scnt_q[csx_pkg::SADDR_W-1:0];
		stk_raddr = '0;
		tot_re    = 1'b0;
		tot_raddr = q_head.id[csx_pkg::TADDR_W-1:0];
		tot_we    = 1'b0;
		tot_waddr = item_q.id[csx_pkg::TADDR_W-1:0];
		tot_wdata = new_tot;
		res_valid = 1'b0;
		res.id     = item_q.id;
		res.status = status_q;
		res.total  = '0;

		unique case (state_q)
			S_IDLE: begin
				if (!q_empty && out_free) begin
					q_pop    = 1'b1;
					item_d   = q_head;
					tot_re   = 1'b1;
					status_d = csx_pkg::ST_OK;
					state_d  = S_LOOK;
					if (q_head.op == csx_pkg::OP_START) begin
						if (scnt_q < csx_pkg::SCNT_W'(csx_pkg::STACK_DEPTH)) begin
							stk_we = 1'b1;
							scnt_d = scnt_q + 1'b1;
						end else begin
							status_d = csx_pkg::ST_FULL;
						end
					end else if (q_head.op == csx_pkg::OP_END) begin
						if (scnt_q != '0) begin
							stk_re    = 1'b1;
							stk_raddr = csx_pkg::SADDR_W'(scnt_q - 1'b1);
							scnt_d    = scnt_q - 1'b1;
						end else begin
							status_d = csx_pkg::ST_EMPTY;
						end
					end
				end
			end
			S_LOOK: begin
				if (item_q.op == csx_pkg::OP_END && status_q == csx_pkg::ST_OK) begin
					dur_d     = cur_dur;
					tot_we    = item_q.id_ok;
					res_tot_d = item_q.id_ok ? new_tot : '0;
					if (scnt_q != '0) begin
						stk_re    = 1'b1;
						stk_raddr = csx_pkg::SADDR_W'(scnt_q - 1'b1);
						state_d   = S_PAR;
					end else begin
						res_valid = 1'b1;
						res.total = res_tot_d;
						state_d   = S_IDLE;
					end
				end else begin
					res_valid = 1'b1;
					res.total = item_q.id_ok ? tot_rd_val : '0;
					state_d   = S_IDLE;
				end
			end
			S_PAR: begin
				tot_re    = 1'b1;
				tot_raddr = par_id[csx_pkg::TADDR_W-1:0];
				state_d   = S_SUB;
			end
			S_SUB: begin
				tot_we    = par_ok;
				tot_waddr = par_id[csx_pkg::TADDR_W-1:0];
				tot_wdata = sub_tot;
				res_valid = 1'b1;
				res.total = (par_ok && par_id == item_q.id) ? sub_tot : res_tot_q;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			item_q    <= '0;
			scnt_q    <= '0;
			status_q  <= csx_pkg::ST_OK;
			dur_q     <= '0;
			res_tot_q <= '0;
		end else begin
			state_q   <= state_d;
			item_q    <= item_d;
			scnt_q    <= scnt_d;
			status_q  <= status_d;
			dur_q     <= dur_d;
			res_tot_q <= res_tot_d;
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= {q_head.id, q_head.ts};
		end
		if (stk_re) begin
			stk_rdata_q <= stk_mem[stk_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (tot_we) begin
			tot_mem[tot_waddr] <= tot_wdata;
		end
		if (tot_re) begin
			tot_rdata_q <= tot_mem[tot_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_vld_q  <= '0;
			tot_rvld_q <= 1'b0;
		end else begin
			if (tot_we) begin
				tot_vld_q[tot_waddr] <= 1'b1;
			end
			if (tot_re) begin
				tot_rvld_q <= tot_vld_q[tot_raddr];
			end
		end
	end

endmodule
